### design/drc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_pkg
// Command and status bundles shared by the reach counter controller and
// datapath.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int unsigned NodeBits    = 10;
  localparam int unsigned CountBits   = 10;
  localparam int unsigned DepthBits   = 4;
  localparam logic [DepthBits-1:0] DepthReset = 4'd3;
  localparam logic [CountBits-1:0] CountMax   = 10'h3FF;

  typedef struct packed {
    logic clr_step;       // clear one list head entry
    logic seen_clr_step;  // clear one visited entry
    logic load_item;      // capture the accepted transaction
    logic add_rd;         // read list head of the edge origin
    logic add_wr;         // link the new edge in
    logic q_init;         // seed the walk with the start node
    logic pop;            // read the frontier at head
    logic head_rd;        // read list head of the popped node
    logic edge_load;      // take list head as current edge
    logic edge_rd;        // read destination and next of current edge
    logic seen_rd;        // read visited bit of the destination
    logic visit;          // mark, push and count an unseen destination
    logic level_adv;      // close one level of the walk
    logic done;           // present the result
  } drc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic add_ok;
    logic q_valid;
    logic walk_go;
    logic level_more;
    logic e_zero;
  } drc_sts_t;

endpackage

### design/drc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_ctrl
// Sequencer for list head clearing after reset, edge insertion, visited map clearing and the level walk.
// ----------------------------------------------------------------------------
module drc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             action_i,
  input  drc_pkg::drc_sts_t sts_i,
  output drc_pkg::drc_cmd_t cmd_o,
  output logic             busy_o
);
  import drc_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_AWR   = 4'd3;
  localparam logic [3:0] S_QCLR  = 4'd4;
  localparam logic [3:0] S_QINIT = 4'd5;
  localparam logic [3:0] S_LOOP  = 4'd6;
  localparam logic [3:0] S_HRD   = 4'd7;
  localparam logic [3:0] S_ELD   = 4'd8;
  localparam logic [3:0] S_EDGE  = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;
  localparam logic [3:0] S_VIS   = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d = action_i ? S_QCLR : S_ARD;
        end
      end
      S_ARD: begin
        if (sts_i.add_ok) begin
          cmd_o.add_rd = 1'b1;
          state_d = S_AWR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AWR: begin
        cmd_o.add_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_QCLR: begin
        cmd_o.seen_clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_QINIT;
      end
      S_QINIT: begin
        if (sts_i.q_valid) begin
          cmd_o.q_init = 1'b1;
          state_d = S_LOOP;
        end else begin
          cmd_o.done = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LOOP: begin
        priority if (!sts_i.walk_go) begin
          cmd_o.done = 1'b1;
          state_d = S_IDLE;
        end else if (sts_i.level_more) begin
          cmd_o.pop = 1'b1;
          state_d = S_HRD;
        end else begin
          cmd_o.level_adv = 1'b1;
        end
      end
      S_HRD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_ELD;
      end
      S_ELD: begin
        cmd_o.edge_load = 1'b1;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if (sts_i.e_zero) begin
          state_d = S_LOOP;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        cmd_o.seen_rd = 1'b1;
        state_d = S_VIS;
      end
      S_VIS: begin
        cmd_o.visit = 1'b1;
        state_d = S_EDGE;
      end
      default: state_d = S_INIT;
    endcase
  end

endmodule

### design/drc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_dp
// Graph store, visited map, frontier queue and walk counters.
// ----------------------------------------------------------------------------
module drc_dp #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 16384
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  drc_pkg::drc_cmd_t               cmd_i,
  output drc_pkg::drc_sts_t               sts_o,
  input  logic [drc_pkg::NodeBits-1:0]    source_node_i,
  input  logic [drc_pkg::NodeBits-1:0]    target_node_i,
  input  logic                            cfg_valid_i,
  input  logic [drc_pkg::DepthBits-1:0]   cfg_wdata_i,
  output logic [drc_pkg::CountBits-1:0]   reached_count_o,
  output logic                            edges_dropped_o,
  output logic                            done_o
);
  import drc_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);

  logic [EW-1:0] list_head_mem [MAX_NODES];
  logic [EW-1:0] edge_next_mem [MAX_EDGES];
  logic [NW-1:0] edge_dest_mem [MAX_EDGES];
  logic          seen_mem      [MAX_NODES];
  logic [NW-1:0] fifo_mem      [MAX_NODES];

  logic [NodeBits-1:0]  src_q, dst_q;
  logic [DepthBits-1:0] depth_q;
  logic [NW-1:0]        clr_q;
  logic [EW-1:0]        fill_q;
  logic                 ovf_q;
  logic [NCW-1:0]       head_q, tail_q, lend_q, reached_q;
  logic [DepthBits-1:0] hops_q;
  logic [EW-1:0]        e_q;
  logic [EW-1:0]        lh_rd_q, en_rd_q;
  logic [NW-1:0]        ed_rd_q, fifo_rd_q, dest_q;
  logic                 seen_rd_q;
  logic                 done_q;
  logic [CountBits-1:0] count_q;

  logic [NW+NodeBits-1:0] src_ext, dst_ext;
  logic [NW-1:0]          src_n, dst_n, lh_raddr;
  logic [EAW-1:0]         e_idx, fill_idx;
  logic [NCW+CountBits-1:0] reached_ext;

  assign src_ext  = {{NW{1'b0}}, src_q};
  assign dst_ext  = {{NW{1'b0}}, dst_q};
  assign src_n    = src_ext[NW-1:0];
  assign dst_n    = dst_ext[NW-1:0];
  assign e_idx    = EAW'(e_q - EW'(1));
  assign fill_idx = EAW'(fill_q);
  assign lh_raddr = cmd_i.add_rd ? src_n : fifo_rd_q;

  assign sts_o.clr_last   = (32'(clr_q) == MAX_NODES - 1);
  assign sts_o.add_ok     = (32'(src_q) < MAX_NODES) && (32'(dst_q) < MAX_NODES);
  assign sts_o.q_valid    = (32'(src_q) < MAX_NODES);
  assign sts_o.walk_go    = (hops_q < depth_q) && (head_q < tail_q);
  assign sts_o.level_more = (head_q < lend_q);
  assign sts_o.e_zero     = (e_q == '0);

  // list heads: clear sweep and edge linking share the write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) list_head_mem[clr_q] <= '0;
    else if (cmd_i.add_wr && (32'(fill_q) < MAX_EDGES))
      list_head_mem[src_n] <= EW'(fill_q + EW'(1));
    if (cmd_i.add_rd || cmd_i.head_rd) lh_rd_q <= list_head_mem[lh_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr && (32'(fill_q) < MAX_EDGES)) begin
      edge_next_mem[fill_idx] <= lh_rd_q;
      edge_dest_mem[fill_idx] <= dst_n;
    end
    if (cmd_i.edge_rd) begin
      en_rd_q <= edge_next_mem[e_idx];
      ed_rd_q <= edge_dest_mem[e_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seen_clr_step) seen_mem[clr_q] <= 1'b0;
    else if (cmd_i.q_init) seen_mem[src_n] <= 1'b1;
    else if (cmd_i.visit && !seen_rd_q && (32'(tail_q) < MAX_NODES))
      seen_mem[dest_q] <= 1'b1;
    if (cmd_i.seen_rd) seen_rd_q <= seen_mem[ed_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_init) fifo_mem[0] <= src_n;
    else if (cmd_i.visit && !seen_rd_q && (32'(tail_q) < MAX_NODES))
      fifo_mem[tail_q[NW-1:0]] <= dest_q;
    if (cmd_i.pop) fifo_rd_q <= fifo_mem[head_q[NW-1:0]];
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      src_q <= source_node_i;
      dst_q <= target_node_i;
    end
    if (cmd_i.seen_rd) dest_q <= ed_rd_q;
  end

  assign reached_ext = {{CountBits{1'b0}}, reached_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DepthReset;
      clr_q     <= '0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      lend_q    <= '0;
      reached_q <= '0;
      hops_q    <= '0;
      e_q       <= '0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      done_q <= cmd_i.done;
      if (cfg_valid_i) depth_q <= cfg_wdata_i;
      if (cmd_i.load_item) begin
        clr_q     <= '0;
        reached_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.seen_clr_step) begin
        clr_q <= NW'(clr_q + NW'(1));
      end
      if (cmd_i.add_wr) begin
        if (32'(fill_q) < MAX_EDGES) fill_q <= EW'(fill_q + EW'(1));
        else ovf_q <= 1'b1;
      end
      if (cmd_i.q_init) begin
        head_q <= '0;
        tail_q <= NCW'(1);
        lend_q <= NCW'(1);
        hops_q <= '0;
      end
      if (cmd_i.pop) head_q <= NCW'(head_q + NCW'(1));
      if (cmd_i.level_adv) begin
        lend_q <= tail_q;
        hops_q <= DepthBits'(hops_q + DepthBits'(1));
      end
      if (cmd_i.edge_load) e_q <= lh_rd_q;
      if (cmd_i.visit) begin
        e_q <= en_rd_q;
        if (!seen_rd_q && (32'(tail_q) < MAX_NODES)) begin
          tail_q    <= NCW'(tail_q + NCW'(1));
          reached_q <= NCW'(reached_q + NCW'(1));
        end
      end
      if (cmd_i.done) begin
        count_q <= (reached_ext > (NCW+CountBits)'(CountMax)) ? CountMax
                                                                : reached_ext[CountBits-1:0];
      end
    end
  end

  assign reached_count_o = count_q;
  assign edges_dropped_o = ovf_q;
  assign done_o          = done_q;

endmodule

### design/depth_limited_reach_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_limited_reach_counter_core
// Directed graph store with a depth limited breadth-first reach count.
// ----------------------------------------------------------------------------
// Usage: drive action_i, source_node_i, target_node_i with start_i high; the
// transaction is taken on a clock edge where busy_o is low. An add transaction
// links one edge if both nodes are below MAX_NODES and the store has room, and
// gives no result. A query clears the visited map one entry a cycle, seeds the
// frontier, then walks level by level: it pops a node, takes its list head as
// the current edge and, per edge, reads destination and next, then the visited
// bit, and marks, pushes and counts an unseen destination; a step closes each
// level. The result is shown on reached_count_o and edges_dropped_o when done_o
// is high for one cycle; the receiver cannot stall it. depth_limit is written
// on the cfg channel (cfg_ready_o is always high); the user must write it only
// while the block is idle, the block itself does not enforce this.
// After reset busy_o stays high while the list heads are cleared; depth_limit
// resets to 3 and the drop flag to zero.
// ----------------------------------------------------------------------------
module depth_limited_reach_counter_core #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic [drc_pkg::NodeBits-1:0]  source_node_i,
  input  logic [drc_pkg::NodeBits-1:0]  target_node_i,
  output logic                          done_o,
  output logic [drc_pkg::CountBits-1:0] reached_count_o,
  output logic                          edges_dropped_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [drc_pkg::DepthBits-1:0] cfg_wdata_i
);
  import drc_pkg::*;

  drc_cmd_t cmd;
  drc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  drc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  drc_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .source_node_i   (source_node_i),
    .target_node_i   (target_node_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .reached_count_o (reached_count_o),
    .edges_dropped_o (edges_dropped_o),
    .done_o          (done_o)
  );

endmodule
